// File: src/hufbp_pkg.sv
// shared types and constants of the huffman table bit packer
package hufbp_pkg;

  localparam int unsigned CodeWidth = 32;
  localparam int unsigned LenWidth  = 6;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned SymWidth  = 9;
  localparam int unsigned AccWidth  = CodeWidth + ByteWidth;

  localparam logic [SymWidth-1:0] EndSymbol = 9'd256;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FINISH = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]           mode;
    logic [SymWidth-1:0]  symbol;
    logic [CodeWidth-1:0] code_bits;
    logic [LenWidth-1:0]  code_length;
  } in_req_t;

  typedef struct packed {
    logic [ByteWidth-1:0] out_byte;
    logic                 last_of_run;
    logic                 end_of_stream;
  } out_req_t;

  // one code to append, handed from the table lookup to the packer
  typedef struct packed {
    logic [CodeWidth-1:0] code;
    logic [LenWidth-1:0]  len;
    logic                 fin;
  } job_t;

endpackage

// File: src/hufbp_packer.sv
// bit packer: merges codes into the pending bits and emits one byte per cycle unless out_ready_i stalls it
module hufbp_packer
  import hufbp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  output logic     job_ready_o,
  input  job_t     job_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_data_o
);

  // acc holds valid bits left aligned, every bit below them is zero
  logic [AccWidth-1:0] acc_q, acc_d;
  logic [LenWidth-1:0] cnt_q, cnt_d;
  logic                fin_q, fin_d;
  logic                out_valid_q, out_valid_d;
  out_req_t            out_q, out_d;

  logic                 is_free;
  logic                 full_byte;
  logic                 out_free;
  logic                 advance;
  logic [CodeWidth-1:0] code_left;
  logic [AccWidth-1:0]  code_ext;
  logic                 last;

  always_comb begin
    full_byte = (cnt_q >= LenWidth'(ByteWidth));
    is_free   = !full_byte && !(fin_q && (cnt_q != '0));
    out_free  = !out_valid_q || out_ready_i;
    advance   = !is_free && out_free;

    code_left = job_i.code << (LenWidth'(CodeWidth) - job_i.len);
    code_ext  = {code_left, {ByteWidth{1'b0}}} >> cnt_q[2:0];

    // a full byte is the last one when under a byte stays and no pad follows
    if (full_byte) begin
      last = (cnt_q < LenWidth'(2 * ByteWidth)) &&
             !(fin_q && (cnt_q != LenWidth'(ByteWidth)));
    end else begin
      last = 1'b1;
    end

    acc_d       = acc_q;
    cnt_d       = cnt_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (advance) begin
      out_valid_d         = 1'b1;
      out_d.out_byte      = acc_q[AccWidth-1 -: ByteWidth];
      out_d.last_of_run   = last;
      out_d.end_of_stream = fin_q && last;
      if (full_byte) begin
        acc_d = acc_q << ByteWidth;
        cnt_d = cnt_q - LenWidth'(ByteWidth);
      end else begin
        acc_d = '0;
        cnt_d = '0;
        fin_d = 1'b0;
      end
    end else if (is_free && job_valid_i) begin
      acc_d = acc_q | code_ext;
      cnt_d = LenWidth'(cnt_q[2:0]) + job_i.len;
      fin_d = job_i.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign job_ready_o = is_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/huffman_table_bit_packer.sv
// top level of the table driven huffman encoder with msb first bit packing
//
// Static huffman encoder. A load request writes the code and length of one
// symbol into the code table (entry 256 is the end-of-stream code); an encode
// request looks up the code of symbol[7:0] and appends it msb first to the
// pending bits; a finish request appends the end code, pads the last partial
// byte with zeros and clears the pending bits. Each completed byte leaves as
// one output request, last_of_run marks the final byte of an input request and
// end_of_stream the final byte of a finish. Lengths above the smaller of
// MAX_CODE_LEN and 32 are saturated; a symbol whose length was never loaded
// appends nothing. After reset the block clears the table entry by entry
// (in_ready_o low). Encode and finish requests pass a registered table read,
// then the packer merges the code and emits one byte per cycle unless the
// output stalls, with the table read of the next item overlapped. The packer
// output is registered, so input requests keep being merged while a byte
// waits for out_ready_i, until the pending bits hold a full byte.
module huffman_table_bit_packer
  import hufbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 257
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_data_o
);

  localparam int unsigned AddrWidth  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int unsigned LenLimit   = (MAX_CODE_LEN < CodeWidth) ? MAX_CODE_LEN : CodeWidth;
  localparam bit          EndInRange = (SYMBOL_COUNT > 256);
  localparam int unsigned WordWidth  = LenWidth + CodeWidth;

  // code table: {length, code}, one write and one read port, read registered
  logic [WordWidth-1:0] table_mem [SYMBOL_COUNT];

  // clearing pass after reset
  logic                 clr_q;
  logic [AddrWidth-1:0] clr_idx_q;

  // lookup stage between the table read and the packer
  logic                 rv_q;
  logic [WordWidth-1:0] rd_q;
  logic                 st_fin_q;
  logic                 st_use_q;

  logic                 in_acc;
  logic                 is_load;
  logic                 is_lookup;
  logic                 is_fin;
  logic [SymWidth-1:0]  rd_sym;
  logic                 rd_in_range;
  logic                 ld_in_range;
  logic [LenWidth-1:0]  len_sat;
  logic [AddrWidth-1:0] rd_addr;
  logic [AddrWidth-1:0] wr_addr;

  job_t                 job;
  logic                 job_ready;
  logic                 job_take;

  always_comb begin
    is_load   = (in_data_i.mode == MODE_LOAD);
    is_fin    = (in_data_i.mode == MODE_FINISH);
    is_lookup = is_fin || (in_data_i.mode == MODE_ENCODE);

    // finish looks up the end code, encode the low byte of the symbol
    rd_sym      = is_fin ? EndSymbol : {1'b0, in_data_i.symbol[7:0]};
    rd_in_range = is_fin ? EndInRange : (32'(rd_sym) < 32'(SYMBOL_COUNT));
    ld_in_range = (32'(in_data_i.symbol) < 32'(SYMBOL_COUNT));
    rd_addr     = AddrWidth'(rd_sym);
    wr_addr     = AddrWidth'(in_data_i.symbol);

    if (32'(in_data_i.code_length) > 32'(LenLimit)) begin
      len_sat = LenWidth'(LenLimit);
    end else begin
      len_sat = in_data_i.code_length;
    end
  end

  // the table is written at the accept edge of a load, so a lookup accepted
  // in the next cycle already reads the new entry
  assign job_take   = rv_q && job_ready;
  assign in_ready_o = !clr_q && (!rv_q || job_ready);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      table_mem[clr_idx_q] <= '0;
    end else if (in_acc && is_load && ld_in_range) begin
      table_mem[wr_addr] <= {len_sat, in_data_i.code_bits};
    end
    if (in_acc && is_lookup) begin
      rd_q     <= table_mem[rd_addr];
      st_fin_q <= is_fin;
      st_use_q <= rd_in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      rv_q      <= 1'b0;
    end else begin
      if (clr_q) begin
        if (clr_idx_q == AddrWidth'(SYMBOL_COUNT - 1)) begin
          clr_q <= 1'b0;
        end
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (in_acc && is_lookup) begin
        rv_q <= 1'b1;
      end else if (job_take) begin
        rv_q <= 1'b0;
      end
    end
  end

  // out of range lookups append nothing but a finish still pads
  always_comb begin
    job.code = rd_q[CodeWidth-1:0];
    job.len  = st_use_q ? rd_q[WordWidth-1 -: LenWidth] : '0;
    job.fin  = st_fin_q;
  end

  hufbp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (rv_q),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench of the huffman table bit packer
module tb_top;
  import hufbp_pkg::*;

  localparam int unsigned MaxCodeLen  = 32;
  localparam int unsigned SymCount    = 257;
  // saturation bound of a loaded length: the smaller of MaxCodeLen and the code width
  localparam int unsigned LenLimit    = (MaxCodeLen < CodeWidth) ? MaxCodeLen : CodeWidth;
  localparam logic [1:0]  ModeUnused  = 2'd3;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned LimitCycles = 400000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_ready_o;
  in_req_t  in_data;
  logic     out_valid_o;
  logic     out_ready;
  out_req_t out_data_o;

  huffman_table_bit_packer #(
    .MAX_CODE_LEN(MaxCodeLen),
    .SYMBOL_COUNT(SymCount)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  // shadow copy of the code table and the pending bits
  logic [CodeWidth-1:0] code_tbl [SymCount];
  logic [LenWidth-1:0]  len_tbl  [SymCount];
  logic [7:0]           pend_bits;
  int unsigned          pend_cnt;

  // bytes still to come, oldest first
  out_req_t exp_bytes [$];

  int unsigned n_accepted;
  int unsigned errors;
  int unsigned cycle_cnt;
  int unsigned n_loads, n_encodes, n_finishes, n_ignored;
  int unsigned n_checked, n_eos;

  // sender burst control and receiver hold request
  bit          tx_gaps_on;
  int unsigned burst_left;
  bit          hold_req;

  out_req_t got_b;
  out_req_t want_b;

  // clock, period 8
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit, counted in clock cycles
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < LimitCycles) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL huffman_table_bit_packer");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction of the packed byte stream
  // ---------------------------------------------------------------------------

  function automatic void push_byte(input logic [7:0] b);
    out_req_t r;
    r.out_byte      = b;
    r.last_of_run   = 1'b0;
    r.end_of_stream = 1'b0;
    exp_bytes.insert(exp_bytes.size(), r);
  endfunction

  // shift one table entry msb first into the pending bits
  function automatic void append_code(input int unsigned idx);
    int unsigned i;
    if (idx >= SymCount) return;
    for (i = len_tbl[idx]; i > 0; i--) begin
      pend_bits = {pend_bits[6:0], code_tbl[idx][i-1]};
      pend_cnt++;
      if (pend_cnt == 8) begin
        push_byte(pend_bits);
        pend_bits = '0;
        pend_cnt  = 0;
      end
    end
  endfunction

  function automatic void predict_bytes(input in_req_t req);
    int unsigned   n0;
    int unsigned   len;
    out_req_t      tail;
    n0 = exp_bytes.size();
    case (req.mode)
      MODE_LOAD: begin
        if (req.symbol < SymCount) begin
          len = (req.code_length > LenLimit) ? LenLimit : req.code_length;
          code_tbl[req.symbol] = req.code_bits;
          len_tbl[req.symbol]  = len[LenWidth-1:0];
          n_loads++;
        end else begin
          n_ignored++;
        end
      end
      MODE_ENCODE: begin
        // only the low byte of the symbol selects the entry
        append_code(int'(req.symbol[7:0]));
        n_encodes++;
      end
      MODE_FINISH: begin
        append_code(int'(EndSymbol));
        // zero pad the partial byte, then start clean
        if (pend_cnt != 0) push_byte(pend_bits << (8 - pend_cnt));
        pend_bits = '0;
        pend_cnt  = 0;
        if (exp_bytes.size() > n0) begin
          tail = exp_bytes[$];
          tail.end_of_stream = 1'b1;
          exp_bytes[$] = tail;
        end
        n_finishes++;
      end
      default: n_ignored++;
    endcase
    if (exp_bytes.size() > n0) begin
      tail = exp_bytes[$];
      tail.last_of_run = 1'b1;
      exp_bytes[$] = tail;
    end
  endfunction

  // accepted requests feed the predictor, values sampled before the edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready_o) begin
      predict_bytes(in_data);
      n_accepted++;
    end
  end

  // every accepted byte against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      got_b = out_data_o;
      n_checked++;
      if (got_b.end_of_stream) n_eos++;
      if (exp_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: expected none, actual %h last %b eos %b",
                 $time, got_b.out_byte, got_b.last_of_run, got_b.end_of_stream);
      end else begin
        want_b = exp_bytes.pop_front();
        if (got_b.out_byte !== want_b.out_byte) begin
          errors++;
          $display("%0t: out_byte: expected %h, actual %h",
                   $time, want_b.out_byte, got_b.out_byte);
        end
        if (got_b.last_of_run !== want_b.last_of_run) begin
          errors++;
          $display("%0t: last_of_run: expected %b, actual %b",
                   $time, want_b.last_of_run, got_b.last_of_run);
        end
        if (got_b.end_of_stream !== want_b.end_of_stream) begin
          errors++;
          $display("%0t: end_of_stream: expected %b, actual %b",
                   $time, want_b.end_of_stream, got_b.end_of_stream);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern of its own, plus one long hold on request
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int unsigned rx_style;
    int unsigned style_left;
    rx_style   = 0;
    style_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // long hold, counted here so the sender keeps pushing meanwhile
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (style_left == 0) begin
          rx_style   = $urandom_range(0, 2);
          style_left = $urandom_range(20, 120);
        end
        style_left--;
        case (rx_style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender; every task starts and ends on a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_req(input logic [1:0] mode, input logic [SymWidth-1:0] sym,
                          input logic [CodeWidth-1:0] code, input logic [LenWidth-1:0] len);
    in_req_t     req;
    int unsigned gap;
    int unsigned want;
    req.mode        = mode;
    req.symbol      = sym;
    req.code_bits   = code;
    req.code_length = len;
    if (tx_gaps_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 16);
        in_valid  <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= req;
    want = n_accepted + 1;
    while (n_accepted < want) @(negedge clk_i);
  endtask

  // sender pauses until every expected byte has come
  task automatic drain_all();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (exp_bytes.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // table extremes: full length, one bit, saturation, zero length, out of range, unused mode
  task automatic test_table_extremes();
    send_req(MODE_LOAD, 9'd0, 32'hFFFF_FFFF, 6'd32);
    send_req(MODE_LOAD, 9'd255, 32'h0000_0001, 6'd1);
    send_req(MODE_LOAD, EndSymbol, 32'h0000_0016, 6'd5);
    send_req(MODE_LOAD, 9'd511, 32'h1234_5678, 6'd8);     // beyond the table
    send_req(MODE_LOAD, 9'd257, 32'h8765_4321, 6'd8);     // first index past the table
    send_req(MODE_LOAD, 9'd1, 32'hA5A5_A5A5, 6'd63);      // saturates to full width
    send_req(MODE_LOAD, 9'd2, 32'h0000_0001, 6'd33);      // saturates too
    send_req(MODE_LOAD, 9'd3, 32'hDEAD_BEEF, 6'd0);       // zero length entry
    send_req(ModeUnused, 9'h1FF, 32'hFFFF_FFFF, 6'd63);   // unused mode
    drain_all();
  endtask

  // encode and finish corner cases
  task automatic test_encode_corners();
    send_req(MODE_ENCODE, 9'd0, 32'h0, 6'd0);             // four full bytes
    send_req(MODE_ENCODE, 9'd255, 32'h0, 6'd0);           // a single bit
    send_req(MODE_ENCODE, 9'h101, 32'hFFFF_FFFF, 6'd63);  // high symbol bit dropped
    send_req(MODE_ENCODE, 9'd3, 32'h0, 6'd0);             // zero length code
    send_req(MODE_ENCODE, 9'd77, 32'h0, 6'd0);            // never loaded
    send_req(MODE_FINISH, 9'd0, 32'h0, 6'd0);             // end code plus padding
    send_req(MODE_ENCODE, 9'd2, 32'h0, 6'd0);
    send_req(MODE_LOAD, EndSymbol, 32'h0, 6'd0);          // no end code any more
    send_req(MODE_FINISH, 9'h1FF, 32'hFFFF_FFFF, 6'd63);  // nothing to flush
    send_req(MODE_ENCODE, 9'd255, 32'h0, 6'd0);
    send_req(MODE_FINISH, 9'd0, 32'h0, 6'd0);             // padding only
    send_req(MODE_LOAD, EndSymbol, 32'h0000_00C3, 6'd8);
    send_req(MODE_ENCODE, 9'd0, 32'h0, 6'd0);
    send_req(MODE_FINISH, 9'd0, 32'h0, 6'd0);             // byte aligned, no padding
    send_req(MODE_ENCODE, 9'h1FF, 32'h0, 6'd0);
    send_req(MODE_FINISH, 9'd0, 32'h0, 6'd0);
    drain_all();
  endtask

  // random streams: a few table loads, a run of encodes, then a finish
  task automatic test_random_streams(input int unsigned n_items);
    int unsigned sent;
    int unsigned k;
    int unsigned sym;
    int unsigned len;
    int unsigned pick;
    int unsigned live [$];
    sent = 0;
    while (sent < n_items) begin
      tx_gaps_on = ($urandom_range(0, 5) != 0);
      k = $urandom_range(3, 10);
      repeat (k) begin
        sym  = ($urandom_range(0, 15) == 0) ? 256 : $urandom_range(0, 255);
        pick = $urandom_range(0, 19);
        if (pick == 0)      len = 0;
        else if (pick == 1) len = $urandom_range(33, 63);
        else if (pick < 4)  len = $urandom_range(13, 32);
        else                len = $urandom_range(1, 12);
        send_req(MODE_LOAD, SymWidth'(sym), $urandom, LenWidth'(len));
        if (len != 0 && sym < 256) live.insert(live.size(), sym);
        sent++;
      end
      k = $urandom_range(8, 30);
      repeat (k) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          // noise the block ignores
          send_req(ModeUnused, SymWidth'($urandom_range(0, 511)), $urandom,
                   LenWidth'($urandom_range(0, 63)));
        end else if (pick == 1) begin
          send_req(MODE_LOAD, SymWidth'($urandom_range(257, 511)), $urandom,
                   LenWidth'($urandom_range(0, 63)));
        end else begin
          if (pick == 2 || live.size() == 0) begin
            sym = $urandom_range(0, 511);
          end else begin
            sym = live[$urandom_range(0, live.size() - 1)] | ($urandom_range(0, 1) << 8);
          end
          send_req(MODE_ENCODE, SymWidth'(sym), $urandom, LenWidth'($urandom_range(0, 63)));
          sent++;
        end
      end
      send_req(MODE_FINISH, SymWidth'($urandom_range(0, 511)), $urandom,
               LenWidth'($urandom_range(0, 63)));
      sent++;
      if ($urandom_range(0, 3) == 0) drain_all();
    end
    tx_gaps_on = 1'b1;
    drain_all();
  endtask

  // receiver holds off while long codes keep coming, so the input backs up
  task automatic test_stall_fill();
    int unsigned i;
    for (i = 10; i < 14; i++) send_req(MODE_LOAD, SymWidth'(i), $urandom, 6'd32);
    send_req(MODE_LOAD, EndSymbol, $urandom, 6'd7);
    hold_req   = 1'b1;
    tx_gaps_on = 1'b0;
    repeat (40) send_req(MODE_ENCODE, SymWidth'($urandom_range(10, 13)), $urandom, 6'd0);
    send_req(MODE_FINISH, 9'd0, 32'h0, 6'd0);
    tx_gaps_on = 1'b1;
    drain_all();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned i;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    hold_req   = 1'b0;
    tx_gaps_on = 1'b1;
    burst_left = 0;
    n_accepted = 0;
    errors     = 0;
    n_loads    = 0;
    n_encodes  = 0;
    n_finishes = 0;
    n_ignored  = 0;
    n_checked  = 0;
    n_eos      = 0;
    pend_bits  = '0;
    pend_cnt   = 0;
    // the code store is only read where a load has set a length
    for (i = 0; i < SymCount; i++) begin
      code_tbl[i] = '0;
      len_tbl[i]  = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_table_extremes();
    test_encode_corners();
    test_stall_fill();
    test_random_streams(340);

    // let any stray byte show up before the verdict
    in_valid <= 1'b0;
    repeat (TailCycles) @(negedge clk_i);
    if (exp_bytes.size() != 0) begin
      errors++;
      $display("%0t: %0d expected bytes never arrived", $time, exp_bytes.size());
    end

    $display("covered %0d loads, %0d encodes, %0d finishes, %0d ignored requests",
             n_loads, n_encodes, n_finishes, n_ignored);
    $display("checked %0d packed bytes, %0d of them closing a stream", n_checked, n_eos);
    if (errors == 0) begin
      $display("PASS huffman_table_bit_packer");
    end else begin
      $display("FAIL huffman_table_bit_packer");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/hufbp_pkg.sv
src/hufbp_packer.sv
src/huffman_table_bit_packer.sv
tb/sv/tb_top.sv
